// ----- rtl/z80ild_pkg.sv -----
// z80ild_pkg: shared types, constants and opcode table functions
`timescale 1ns / 1ps
package z80ild_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] PFX_CB = 8'hCB;
   localparam logic [7:0] PFX_ED = 8'hED;
   localparam logic [7:0] PFX_DD = 8'hDD;
   localparam logic [7:0] PFX_FD = 8'hFD;

   typedef enum logic [2:0] {
      KIND_NONE    = 3'd0,
      KIND_IMM8    = 3'd1,
      KIND_IMM16   = 3'd2,
      KIND_REL     = 3'd3,
      KIND_DISP    = 3'd4,
      KIND_DISPIMM = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      SEL_BASE = 3'd0,
      SEL_CB   = 3'd1,
      SEL_ED   = 3'd2,
      SEL_DD   = 3'd3,
      SEL_FD   = 3'd4,
      SEL_DDCB = 3'd5,
      SEL_FDCB = 3'd6
   } sel_type;

   typedef struct packed {
      logic       ok;
      logic [4:0] t;
      logic [4:0] t2;
      kind_type   kind;
   } entry_type;

   // classified request handed from front to back
   typedef struct packed {
      logic [15:0] addr;
      logic [7:0]  b1;
      logic [7:0]  b2;
      logic [7:0]  b3;
      logic        pre2;
      logic        undef;
      logic [4:0]  t;
      logic [4:0]  t2;
      sel_type     sel;
      logic [7:0]  idx;
      kind_type    kind;
   } front_type;

   // unprefixed t-states, 0x00-0x3f then 0xc0-0xff, 0 for prefix slots
   localparam logic [4:0] EDGE_T [128] = '{
      5'd4,5'd10,5'd7,5'd6,5'd4,5'd4,5'd7,5'd4, 5'd4,5'd11,5'd7,5'd6,5'd4,5'd4,5'd7,5'd4,
      5'd13,5'd10,5'd7,5'd6,5'd4,5'd4,5'd7,5'd4, 5'd12,5'd11,5'd7,5'd6,5'd4,5'd4,5'd7,5'd4,
      5'd12,5'd10,5'd16,5'd6,5'd4,5'd4,5'd7,5'd4, 5'd12,5'd11,5'd16,5'd6,5'd4,5'd4,5'd7,5'd4,
      5'd12,5'd10,5'd13,5'd6,5'd11,5'd11,5'd10,5'd4,
      5'd12,5'd11,5'd13,5'd6,5'd4,5'd4,5'd7,5'd4,
      5'd11,5'd10,5'd10,5'd10,5'd17,5'd11,5'd7,5'd11,
      5'd11,5'd10,5'd10,5'd0,5'd17,5'd17,5'd7,5'd11,
      5'd11,5'd10,5'd10,5'd11,5'd17,5'd11,5'd7,5'd11,
      5'd11,5'd4,5'd10,5'd11,5'd17,5'd0,5'd7,5'd11,
      5'd11,5'd10,5'd10,5'd19,5'd17,5'd11,5'd7,5'd11,
      5'd11,5'd4,5'd10,5'd4,5'd17,5'd0,5'd7,5'd11,
      5'd11,5'd10,5'd10,5'd4,5'd17,5'd11,5'd7,5'd11,
      5'd11,5'd6,5'd10,5'd4,5'd17,5'd0,5'd7,5'd11
   };

   function automatic entry_type base_entry(input logic [7:0] op);
      entry_type  e;
      logic [2:0] col;
      logic       mem;
      col    = op[2:0];
      e.ok   = 1'b1;
      e.t2   = 5'd0;
      e.kind = KIND_NONE;
      e.t    = 5'd4;
      if (op >= 8'h40 && op < 8'hC0) begin
         mem = (col == 3'd6) || (op[7:3] == 5'b01110);
         e.t = (mem && op != 8'h76) ? 5'd7 : 5'd4;
      end else if (op < 8'h40) begin
         e.t = EDGE_T[op[6:0]];
         if (op[3:0] == 4'h1 || op == 8'h22 || op == 8'h2A || op == 8'h32 || op == 8'h3A)
            e.kind = KIND_IMM16;
         else if (col == 3'd6)
            e.kind = KIND_IMM8;
         else if (op == 8'h10 || (op >= 8'h18 && col == 3'd0))
            e.kind = KIND_REL;
         if (op == 8'h10)
            e.t2 = 5'd8;
         else if (op >= 8'h20 && col == 3'd0)
            e.t2 = 5'd7;
      end else begin
         e.t = EDGE_T[{1'b1, op[5:0]}];
         e.ok = (e.t != 5'd0);
         if (col == 3'd2 || col == 3'd4 || op == 8'hC3 || op == 8'hCD)
            e.kind = KIND_IMM16;
         else if (col == 3'd6 || op == 8'hD3 || op == 8'hDB)
            e.kind = KIND_IMM8;
         if (col == 3'd0)
            e.t2 = 5'd5;
         else if (col == 3'd4)
            e.t2 = 5'd10;
      end
      return e;
   endfunction

   function automatic entry_type ed_entry(input logic [7:0] op);
      entry_type e;
      e.ok   = 1'b0;
      e.t    = 5'd4;
      e.t2   = 5'd0;
      e.kind = KIND_NONE;
      if (op >= 8'h40 && op < 8'h80) begin
         e.ok = 1'b1;
         case (op[2:0])
            3'd0, 3'd1: e.t = 5'd12;
            3'd2: e.t = 5'd15;
            3'd3: begin
               e.t    = 5'd20;
               e.kind = KIND_IMM16;
            end
            3'd4, 3'd6: e.t = 5'd8;
            3'd5: e.t = 5'd14;
            default: begin
               if (op < 8'h60) e.t = 5'd9;
               else if (op < 8'h70) e.t = 5'd18;
               else e.ok = 1'b0;
            end
         endcase
      end else if ((op & 8'hE4) == 8'hA0) begin
         e.ok = 1'b1;
         if (op >= 8'hB0) begin
            e.t  = 5'd21;
            e.t2 = 5'd16;
         end else begin
            e.t = 5'd16;
         end
      end
      return e;
   endfunction

   function automatic entry_type ix_entry(input logic [7:0] op);
      entry_type  e;
      logic [4:0] row;
      row    = op[7:3];
      e.ok   = 1'b1;
      e.t    = 5'd4;
      e.t2   = 5'd0;
      e.kind = KIND_NONE;
      if (op >= 8'h40 && op < 8'hC0) begin
         if (op == 8'h76) begin
            e.ok = 1'b0;
         end else if (op < 8'h80 && row inside {5'd12, 5'd13, 5'd14}) begin
            if (row == 5'd14 || op[2:0] == 3'd6) begin
               e.t    = 5'd19;
               e.kind = KIND_DISP;
            end else begin
               e.t = 5'd8;
            end
         end else if (op[2:0] == 3'd4 || op[2:0] == 3'd5) begin
            e.t = 5'd8;
         end else if (op[2:0] == 3'd6) begin
            e.t    = 5'd19;
            e.kind = KIND_DISP;
         end else begin
            e.ok = 1'b0;
         end
      end else begin
         case (op)
            8'h09, 8'h19, 8'h29, 8'h39: e.t = 5'd15;
            8'h21: begin
               e.t    = 5'd14;
               e.kind = KIND_IMM16;
            end
            8'h22, 8'h2A: begin
               e.t    = 5'd20;
               e.kind = KIND_IMM16;
            end
            8'h23, 8'h2B: e.t = 5'd10;
            8'h24, 8'h25, 8'h2C, 8'h2D: e.t = 5'd8;
            8'h26, 8'h2E: begin
               e.t    = 5'd11;
               e.kind = KIND_IMM8;
            end
            8'h34, 8'h35: begin
               e.t    = 5'd23;
               e.kind = KIND_DISP;
            end
            8'h36: begin
               e.t    = 5'd19;
               e.kind = KIND_DISPIMM;
            end
            8'hE1: e.t = 5'd14;
            8'hE3: e.t = 5'd23;
            8'hE5: e.t = 5'd15;
            8'hE9: e.t = 5'd8;
            8'hF9: e.t = 5'd10;
            default: e.ok = 1'b0;
         endcase
      end
      return e;
   endfunction

endpackage

// ----- rtl/z80ild_if.sv -----
// z80ild_if: request and response channel interfaces
`timescale 1ns / 1ps
interface z80ild_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] fetch_address;
   logic [7:0]  instr_byte0;
   logic [7:0]  instr_byte1;
   logic [7:0]  instr_byte2;
   logic [7:0]  instr_byte3;
   modport source (output valid, fetch_address, instr_byte0, instr_byte1, instr_byte2,
                   instr_byte3, input ready);
   modport sink (input valid, fetch_address, instr_byte0, instr_byte1, instr_byte2,
                 instr_byte3, output ready);
endinterface

interface z80ild_rsp_if;
   logic              valid;
   logic              ready;
   logic [2:0]        instr_length;
   logic [4:0]        cycles_nominal;
   logic [4:0]        cycles_alternate;
   logic              is_undefined;
   logic [2:0]        table_select;
   logic [7:0]        opcode_index;
   logic [2:0]        operand_kind;
   logic [15:0]       immediate_value;
   logic signed [7:0] displacement;
   logic [15:0]       branch_target;
   modport source (output valid, instr_length, cycles_nominal, cycles_alternate,
                   is_undefined, table_select, opcode_index, operand_kind,
                   immediate_value, displacement, branch_target, input ready);
   modport sink (input valid, instr_length, cycles_nominal, cycles_alternate,
                 is_undefined, table_select, opcode_index, operand_kind,
                 immediate_value, displacement, branch_target, output ready);
endinterface

// ----- rtl/z80_instruction_length_timing_decoder.sv -----
// z80_instruction_length_timing_decoder: top level of the z80 length and timing decoder
// Decodes one z80 instruction per request from a 16-bit address and a four-byte fetch
// window, one request per cycle sustained with both sides ready. From acceptance to
// response a request passes the classify register of the front, the queue between
// front and back, and the response register after the target adder.
// Front and back stall independently through the queue of QUEUE_DEPTH entries.
`timescale 1ns / 1ps
module z80_instruction_length_timing_decoder #(
   parameter int QUEUE_DEPTH = z80ild_pkg::QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   z80ild_req_if.sink   req,
   z80ild_rsp_if.source rsp
);

   logic                  f_valid, f_ready, b_valid, b_ready;
   z80ild_pkg::front_type f_data, b_data;

   z80ild_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .front_valid (f_valid),
      .front_ready (f_ready),
      .front_data  (f_data)
   );

   z80ild_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (f_data),
      .pop_valid  (b_valid),
      .pop_ready  (b_ready),
      .pop_data   (b_data)
   );

   z80ild_back u_back (
      .clock      (clock),
      .reset      (reset),
      .back_valid (b_valid),
      .back_ready (b_ready),
      .back_data  (b_data),
      .rsp        (rsp)
   );

endmodule

// ----- rtl/z80ild_front.sv -----
// z80ild_front: accepts requests and classifies prefix, table and timing
`timescale 1ns / 1ps
module z80ild_front (
   input  logic                  clock,
   input  logic                  reset,
   z80ild_req_if.sink            req,
   output logic                  front_valid,
   input  logic                  front_ready,
   output z80ild_pkg::front_type front_data
);

   logic                  vld_ff, vld_in;
   z80ild_pkg::front_type dat_ff, dat_in;
   z80ild_pkg::entry_type e_base0, e_base1, e_ed, e_ix;
   logic [7:0]            b0, b1, b3;

   assign req.ready   = !vld_ff || front_ready;
   assign front_valid = vld_ff;
   assign front_data  = dat_ff;

   assign b0 = req.instr_byte0;
   assign b1 = req.instr_byte1;
   assign b3 = req.instr_byte3;

   always_comb begin
      e_base0 = z80ild_pkg::base_entry(b0);
      e_base1 = z80ild_pkg::base_entry(b1);
      e_ed    = z80ild_pkg::ed_entry(b1);
      e_ix    = z80ild_pkg::ix_entry(b1);
      dat_in.addr  = req.fetch_address;
      dat_in.b1    = b1;
      dat_in.b2    = req.instr_byte2;
      dat_in.b3    = b3;
      dat_in.pre2  = 1'b1;
      dat_in.undef = 1'b0;
      dat_in.t     = e_base0.t;
      dat_in.t2    = e_base0.t2;
      dat_in.sel   = z80ild_pkg::SEL_BASE;
      dat_in.idx   = b1;
      dat_in.kind  = e_base0.kind;
      if (b0 == z80ild_pkg::PFX_CB) begin
         dat_in.sel  = z80ild_pkg::SEL_CB;
         dat_in.t2   = 5'd0;
         dat_in.kind = z80ild_pkg::KIND_NONE;
         dat_in.t    = (b1[2:0] == 3'd6) ? ((b1 >= 8'h40 && b1 < 8'h80) ? 5'd12 : 5'd15)
                                         : 5'd8;
      end else if (b0 == z80ild_pkg::PFX_ED) begin
         dat_in.sel   = z80ild_pkg::SEL_ED;
         dat_in.undef = !e_ed.ok;
         dat_in.t     = e_ed.t;
         dat_in.t2    = e_ed.t2;
         dat_in.kind  = e_ed.kind;
      end else if (b0 == z80ild_pkg::PFX_DD || b0 == z80ild_pkg::PFX_FD) begin
         if (b1 == z80ild_pkg::PFX_CB) begin
            dat_in.sel  = (b0 == z80ild_pkg::PFX_DD) ? z80ild_pkg::SEL_DDCB
                                                     : z80ild_pkg::SEL_FDCB;
            dat_in.idx  = b3;
            dat_in.t    = (b3 >= 8'h40 && b3 < 8'h80) ? 5'd20 : 5'd23;
            dat_in.t2   = 5'd0;
            dat_in.kind = z80ild_pkg::KIND_DISP;
         end else if (e_ix.ok) begin
            dat_in.sel  = (b0 == z80ild_pkg::PFX_DD) ? z80ild_pkg::SEL_DD
                                                     : z80ild_pkg::SEL_FD;
            dat_in.t    = e_ix.t;
            dat_in.t2   = 5'd0;
            dat_in.kind = e_ix.kind;
         end else begin
            dat_in.undef = !e_base1.ok;
            dat_in.t     = e_base1.t;
            dat_in.t2    = e_base1.t2;
            dat_in.kind  = e_base1.kind;
         end
      end else begin
         dat_in.pre2 = 1'b0;
         dat_in.idx  = b0;
      end
      if (dat_in.undef) begin
         dat_in.t    = 5'd4;
         dat_in.t2   = 5'd0;
         dat_in.kind = z80ild_pkg::KIND_NONE;
      end
   end

   assign vld_in = req.ready ? req.valid : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (req.valid && req.ready) begin
         dat_ff <= dat_in;
      end
   end

endmodule

// ----- rtl/z80ild_fifo.sv -----
// z80ild_fifo: short queue of classified requests between front and back
`timescale 1ns / 1ps
module z80ild_fifo #(
   parameter int DEPTH = z80ild_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  z80ild_pkg::front_type push_data,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output z80ild_pkg::front_type pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   z80ild_pkg::front_type mem [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          push, pop;

   assign push_ready = (cnt_ff != CW'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = mem[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_in  = push ? ((wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = pop ? ((rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem[wr_ff] <= push_data;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH)) else $error("queue count overflow");
   a_cnt_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 1'b1)) else $error("count lost a push");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (wr_ff == rd_ff)) else $error("pointers differ when empty");

endmodule

// ----- rtl/z80ild_back.sv -----
// z80ild_back: operand extraction, length, branch target and response register
`timescale 1ns / 1ps
module z80ild_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  back_valid,
   output logic                  back_ready,
   input  z80ild_pkg::front_type back_data,
   z80ild_rsp_if.source          rsp
);

   logic              vld_ff, vld_in;
   logic [2:0]        len_ff, len_in;
   logic [4:0]        t_ff, t2_ff;
   logic              undef_ff;
   logic [2:0]        sel_ff;
   logic [7:0]        idx_ff;
   logic [2:0]        kind_ff, kind_in;
   logic [15:0]       imm_ff, imm_in;
   logic [7:0]        disp_ff, disp_in;
   logic [15:0]       tgt_ff, tgt_in;
   logic [7:0]        p0, p1;
   logic [2:0]        pre;

   assign back_ready = !vld_ff || rsp.ready;

   always_comb begin
      pre     = back_data.pre2 ? 3'd2 : 3'd1;
      p0      = back_data.pre2 ? back_data.b2 : back_data.b1;
      p1      = back_data.pre2 ? back_data.b3 : back_data.b2;
      kind_in = back_data.kind;
      imm_in  = 16'd0;
      disp_in = 8'd0;
      tgt_in  = 16'd0;
      len_in  = pre;
      if (back_data.undef) begin
         len_in = pre;
      end else if (back_data.sel == z80ild_pkg::SEL_DDCB ||
                   back_data.sel == z80ild_pkg::SEL_FDCB) begin
         len_in  = 3'd4;
         disp_in = back_data.b2;
      end else begin
         case (back_data.kind)
            z80ild_pkg::KIND_IMM8: begin
               imm_in = {8'd0, p0};
               len_in = pre + 3'd1;
            end
            z80ild_pkg::KIND_IMM16: begin
               imm_in = {p1, p0};
               len_in = pre + 3'd2;
            end
            z80ild_pkg::KIND_REL: begin
               disp_in = p0;
               len_in  = pre + 3'd1;
               tgt_in  = back_data.addr + {13'd0, pre} + 16'd1 + {{8{p0[7]}}, p0};
            end
            z80ild_pkg::KIND_DISP: begin
               disp_in = p0;
               len_in  = pre + 3'd1;
            end
            z80ild_pkg::KIND_DISPIMM: begin
               disp_in = p0;
               imm_in  = {8'd0, p1};
               len_in  = pre + 3'd2;
            end
            default: len_in = pre;
         endcase
      end
   end

   assign vld_in = back_ready ? back_valid : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (back_valid && back_ready) begin
         len_ff   <= len_in;
         t_ff     <= back_data.t;
         t2_ff    <= back_data.t2;
         undef_ff <= back_data.undef;
         sel_ff   <= back_data.sel;
         idx_ff   <= back_data.idx;
         kind_ff  <= kind_in;
         imm_ff   <= imm_in;
         disp_ff  <= disp_in;
         tgt_ff   <= tgt_in;
      end
   end

   assign rsp.valid            = vld_ff;
   assign rsp.instr_length     = len_ff;
   assign rsp.cycles_nominal   = t_ff;
   assign rsp.cycles_alternate = t2_ff;
   assign rsp.is_undefined     = undef_ff;
   assign rsp.table_select     = sel_ff;
   assign rsp.opcode_index     = idx_ff;
   assign rsp.operand_kind     = kind_ff;
   assign rsp.immediate_value  = imm_ff;
   assign rsp.displacement     = disp_ff;
   assign rsp.branch_target    = tgt_ff;

endmodule
